[hw/rtl/sit_pkg.sv]
// ============================================================================
// sit_pkg: shared types and constants of the sorted interval table
// Holds the table capacity, operation and status codes, the item and result
// payload structs, the stored entry layout and the controller/datapath links.
// ============================================================================
package sit_pkg;

    localparam int CAPACITY = 32;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam logic [2:0] MODE_BIND   = 3'd0;
    localparam logic [2:0] MODE_CLEAR  = 3'd1;
    localparam logic [2:0] MODE_ADD    = 3'd2;
    localparam logic [2:0] MODE_REMOVE = 3'd3;
    localparam logic [2:0] MODE_GET    = 3'd4;
    localparam logic [2:0] MODE_FIND   = 3'd5;

    localparam logic [2:0] ST_VALID    = 3'd0;
    localparam logic [2:0] ST_BADARG   = 3'd1;
    localparam logic [2:0] ST_MISMATCH = 3'd2;
    localparam logic [2:0] ST_RANGE    = 3'd3;
    localparam logic [2:0] ST_OVERLAP  = 3'd4;
    localparam logic [2:0] ST_FULL     = 3'd5;
    localparam logic [2:0] ST_NOTFOUND = 3'd6;

    localparam logic [2:0] KIND_MAX = 3'd5;

    typedef struct packed {
        logic [2:0]  mode;
        logic [31:0] src_generation;
        logic [31:0] src_fingerprint;
        logic [15:0] src_pulse_count;
        logic [2:0]  kind;
        logic [15:0] first_pulse;
        logic [15:0] last_pulse;
        logic [7:0]  item_index;
        logic [15:0] probe_pulse;
    } t_item;

    typedef struct packed {
        logic [2:0]  status;
        logic        hit;
        logic [7:0]  hit_index;
        logic [2:0]  hit_kind;
        logic [15:0] hit_first;
        logic [15:0] hit_last;
        logic [7:0]  entry_total;
    } t_result;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] first;
        logic [15:0] last;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic load;
        logic check;
        logic scan;
        logic shift_init;
        logic shift;
        logic move;
        logic get;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic [2:0] mode;
        logic       pre_ok;
        logic       scan_hit;
        logic       scan_end;
        logic       shift_end;
        logic       move_end;
    } t_sts;

endpackage

[hw/rtl/sit_ram.sv]
// ============================================================================
// sit_ram: generic simple dual-port RAM
// One write port and one read port with a registered read data output.
// ============================================================================
module sit_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[hw/rtl/sit_ctrl.sv]
// ============================================================================
// sit_ctrl: operation sequencer of the sorted interval table
// Steps each transaction through check, then the scan, shift, move or read that its mode needs, and finish.
// ============================================================================
module sit_ctrl import sit_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    output logic o_busy,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_SHIFT = 3'd3;
    localparam logic [2:0] S_MOVE  = 3'd4;
    localparam logic [2:0] S_GET   = 3'd5;
    localparam logic [2:0] S_FIN   = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                o_cmd.check = 1'b1;
                n_state     = S_FIN;
                if (i_sts.pre_ok) begin
                    case (i_sts.mode)
                        MODE_ADD, MODE_FIND: n_state = S_SCAN;
                        MODE_REMOVE:         n_state = S_MOVE;
                        MODE_GET:            n_state = S_GET;
                        default:             n_state = S_FIN;
                    endcase
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_hit) begin
                    n_state = S_FIN;
                end else if (i_sts.scan_end) begin
                    if (i_sts.mode == MODE_ADD) begin
                        o_cmd.shift_init = 1'b1;
                        n_state          = S_SHIFT;
                    end else begin
                        n_state = S_FIN;
                    end
                end
            end
            S_SHIFT: begin
                o_cmd.shift = 1'b1;
                if (i_sts.shift_end) begin
                    n_state = S_FIN;
                end
            end
            S_MOVE: begin
                o_cmd.move = 1'b1;
                if (i_sts.move_end) begin
                    n_state = S_FIN;
                end
            end
            S_GET: begin
                o_cmd.get = 1'b1;
                n_state   = S_FIN;
            end
            S_FIN: begin
                o_cmd.finish = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

[hw/rtl/sit_dp.sv]
// ============================================================================
// sit_dp: datapath of the sorted interval table
// Holds the binding, entry count, scan pointers and result register, and
// drives the entry RAM for scans, gap shifts, removal moves, reads and inserts.
// ============================================================================
module sit_dp import sit_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_item            i_item,
    input  t_cmd             i_cmd,
    output t_sts             o_sts,
    output logic             o_done,
    output t_result          o_result,
    output logic             o_wr_en,
    output logic [IDX_W-1:0] o_wr_addr,
    output logic [ENTRY_W-1:0] o_wr_data,
    output logic             o_rd_en,
    output logic [IDX_W-1:0] o_rd_addr,
    input  logic [ENTRY_W-1:0] i_rd_data
);

    t_item            r_item;
    logic             r_bound;
    logic [31:0]      r_gen;
    logic [31:0]      r_fp;
    logic [15:0]      r_pc;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] r_ptr;
    logic             r_dv;
    logic [IDX_W-1:0] r_didx;
    logic [CNT_W-1:0] r_pos;
    logic             r_pos_set;
    logic             r_found;
    logic [IDX_W-1:0] r_fidx;
    t_entry           r_fdata;
    logic             r_done;
    t_result          r_res;

    t_entry           rd_entry;
    t_entry           new_entry;
    logic             src_match;
    logic             idx_ok;
    logic             full;
    logic [2:0]       pre_status;
    logic [2:0]       fin_status;
    logic [CNT_W-1:0] n_count;
    logic [CNT_W-1:0] ptr_m1;
    logic             ptr_lt_cnt;
    logic             ptr_gt_pos;
    logic             ovl;
    logic             cov;
    logic             scan_hit;
    t_result          res;

    assign rd_entry  = t_entry'(i_rd_data);
    assign new_entry = '{kind: r_item.kind, first: r_item.first_pulse,
                         last: r_item.last_pulse};

    assign src_match = r_bound && (r_item.src_generation == r_gen) &&
                       (r_item.src_fingerprint == r_fp) &&
                       (r_item.src_pulse_count == r_pc);
    assign idx_ok    = r_item.item_index < 8'(r_count);
    assign full      = (r_count == CNT_W'(CAPACITY));

    always_comb begin
        case (r_item.mode)
            MODE_BIND: begin
                pre_status = (r_item.src_pulse_count == 16'd0) ? ST_BADARG : ST_VALID;
            end
            MODE_CLEAR: pre_status = ST_VALID;
            MODE_ADD: begin
                if (r_item.src_pulse_count == 16'd0 || r_item.kind > KIND_MAX) begin
                    pre_status = ST_BADARG;
                end else if (!src_match) begin
                    pre_status = ST_MISMATCH;
                end else if (r_item.first_pulse > r_item.last_pulse ||
                             r_item.last_pulse >= r_pc) begin
                    pre_status = ST_RANGE;
                end else if (full) begin
                    pre_status = ST_FULL;
                end else begin
                    pre_status = ST_VALID;
                end
            end
            MODE_REMOVE: begin
                if (!src_match) begin
                    pre_status = ST_MISMATCH;
                end else if (!idx_ok) begin
                    pre_status = ST_NOTFOUND;
                end else begin
                    pre_status = ST_VALID;
                end
            end
            MODE_GET:  pre_status = idx_ok ? ST_VALID : ST_NOTFOUND;
            MODE_FIND: pre_status = (r_item.probe_pulse < r_pc) ? ST_VALID : ST_NOTFOUND;
            default:   pre_status = ST_BADARG;
        endcase
    end

    // Scan and move walk up from the pointer; the shift walks down to the
    // insert position.
    assign ptr_m1     = r_ptr - CNT_W'(1);
    assign ptr_lt_cnt = r_ptr < r_count;
    assign ptr_gt_pos = r_ptr > r_pos;

    assign ovl = (rd_entry.first <= r_item.last_pulse) &&
                 (r_item.first_pulse <= rd_entry.last);
    assign cov = (rd_entry.first <= r_item.probe_pulse) &&
                 (r_item.probe_pulse <= rd_entry.last);
    assign scan_hit = r_dv && ((r_item.mode == MODE_ADD) ? ovl : cov);

    assign o_sts = '{mode: r_item.mode, pre_ok: (pre_status == ST_VALID),
                     scan_hit: scan_hit, scan_end: !r_dv && !ptr_lt_cnt,
                     shift_end: !r_dv && !ptr_gt_pos, move_end: !r_dv && !ptr_lt_cnt};

    always_comb begin
        o_rd_en   = 1'b0;
        o_rd_addr = '0;
        if ((i_cmd.scan || i_cmd.move) && ptr_lt_cnt) begin
            o_rd_en   = 1'b1;
            o_rd_addr = r_ptr[IDX_W-1:0];
        end else if (i_cmd.shift && ptr_gt_pos) begin
            o_rd_en   = 1'b1;
            o_rd_addr = ptr_m1[IDX_W-1:0];
        end else if (i_cmd.get) begin
            o_rd_en   = 1'b1;
            o_rd_addr = r_item.item_index[IDX_W-1:0];
        end
    end

    always_comb begin
        fin_status = pre_status;
        if (pre_status == ST_VALID) begin
            if (r_item.mode == MODE_ADD) begin
                fin_status = r_found ? ST_OVERLAP : ST_VALID;
            end else if (r_item.mode == MODE_FIND) begin
                fin_status = r_found ? ST_VALID : ST_NOTFOUND;
            end
        end
        n_count = r_count;
        case (r_item.mode)
            MODE_BIND: begin
                if (fin_status == ST_VALID) n_count = '0;
            end
            MODE_CLEAR: n_count = '0;
            MODE_ADD: begin
                if (fin_status == ST_VALID) n_count = r_count + CNT_W'(1);
            end
            MODE_REMOVE: begin
                if (fin_status == ST_VALID) n_count = r_count - CNT_W'(1);
            end
            default: n_count = r_count;
        endcase
    end

    always_comb begin
        o_wr_en   = 1'b0;
        o_wr_addr = r_didx;
        o_wr_data = i_rd_data;
        if ((i_cmd.shift || i_cmd.move) && r_dv) begin
            o_wr_en = 1'b1;
        end else if (i_cmd.finish && r_item.mode == MODE_ADD && fin_status == ST_VALID) begin
            o_wr_en   = 1'b1;
            o_wr_addr = r_pos[IDX_W-1:0];
            o_wr_data = new_entry;
        end
    end

    always_comb begin
        res             = '0;
        res.status      = fin_status;
        res.entry_total = 8'(n_count);
        if (r_item.mode == MODE_GET && fin_status == ST_VALID) begin
            res.hit       = 1'b1;
            res.hit_index = r_item.item_index;
            res.hit_kind  = rd_entry.kind;
            res.hit_first = rd_entry.first;
            res.hit_last  = rd_entry.last;
        end else if (r_item.mode == MODE_FIND && fin_status == ST_VALID) begin
            res.hit       = 1'b1;
            res.hit_index = 8'(r_fidx);
            res.hit_kind  = r_fdata.kind;
            res.hit_first = r_fdata.first;
            res.hit_last  = r_fdata.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bound <= 1'b0;
            r_gen   <= '0;
            r_fp    <= '0;
            r_pc    <= '0;
            r_count <= '0;
            r_dv    <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_done <= i_cmd.finish;
            if (i_cmd.check || i_cmd.shift_init) begin
                r_dv <= 1'b0;
            end else if (i_cmd.scan || i_cmd.move) begin
                r_dv <= ptr_lt_cnt;
            end else if (i_cmd.shift) begin
                r_dv <= ptr_gt_pos;
            end else begin
                r_dv <= 1'b0;
            end
            if (i_cmd.finish) begin
                r_count <= n_count;
                if (r_item.mode == MODE_BIND && fin_status == ST_VALID) begin
                    r_bound <= 1'b1;
                    r_gen   <= r_item.src_generation;
                    r_fp    <= r_item.src_fingerprint;
                    r_pc    <= r_item.src_pulse_count;
                end else if (r_item.mode == MODE_CLEAR) begin
                    r_bound <= 1'b0;
                    r_gen   <= '0;
                    r_fp    <= '0;
                    r_pc    <= '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_item;
        end
        if (i_cmd.check) begin
            r_ptr     <= (r_item.mode == MODE_REMOVE) ?
                         r_item.item_index[CNT_W-1:0] + CNT_W'(1) : '0;
            r_pos     <= r_count;
            r_pos_set <= 1'b0;
            r_found   <= 1'b0;
        end else if (i_cmd.shift_init) begin
            r_ptr <= r_count;
        end else if (i_cmd.scan && ptr_lt_cnt) begin
            r_ptr  <= r_ptr + CNT_W'(1);
            r_didx <= r_ptr[IDX_W-1:0];
        end else if (i_cmd.move && ptr_lt_cnt) begin
            r_ptr  <= r_ptr + CNT_W'(1);
            r_didx <= ptr_m1[IDX_W-1:0];
        end else if (i_cmd.shift && ptr_gt_pos) begin
            r_ptr  <= ptr_m1;
            r_didx <= r_ptr[IDX_W-1:0];
        end
        if (i_cmd.scan && r_dv) begin
            if (scan_hit && !r_found) begin
                r_found <= 1'b1;
                r_fidx  <= r_didx;
                r_fdata <= rd_entry;
            end
            if (!r_pos_set && r_item.first_pulse < rd_entry.first) begin
                r_pos     <= CNT_W'(r_didx);
                r_pos_set <= 1'b1;
            end
        end
        if (i_cmd.finish) begin
            r_res <= res;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_res;

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("result strobe held for more than one cycle");

    a_hit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && r_res.hit) |-> (r_res.status == ST_VALID))
        else $error("entry returned with a failing status");

endmodule

[hw/rtl/sorted_interval_table.sv]
// ============================================================================
// sorted_interval_table: sorted table of labelled, non-overlapping intervals
// Bind, clear, add, remove, get and find operations on a pulse-interval table.
// ============================================================================
// Usage: drive an operation on i_item and raise start while busy is low; the
// transaction is accepted at that clock edge and busy rises the next cycle.
// Exactly one result follows: o_result is valid for the single cycle in which
// o_done is high, and busy is already low in that cycle, so a new start may be
// accepted at the same edge. The receiver cannot stall the result.
// Steps after accept: bind, clear and failed checks go straight to finish;
// get reads one entry; find scans the entries until one covers the probe;
// remove at index k moves each entry above k down one place; add scans the
// entries for an overlap, then shifts the tail above the insert position up
// one place and writes the new entry at that position. The entry RAM gives
// one registered read and one write per cycle: the overlap scan and the gap
// shift each walk it once, and each walk fills and drains the read.
// Reset clears the binding, the entry count and the sequencer; the entry RAM
// is not cleared, since only entries below the count are ever read.
// ============================================================================
module sorted_interval_table import sit_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    input  t_item   i_item,
    output logic    busy,
    output logic    o_done,
    output t_result o_result
);

    t_cmd               cmd;
    t_sts               sts;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [ENTRY_W-1:0] wr_data;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic [ENTRY_W-1:0] rd_data;

    // The sequencer takes start and drives busy; the datapath follows its commands and raises the done strobe.
    sit_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    sit_dp u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_item    (i_item),
        .i_cmd     (cmd),
        .o_sts     (sts),
        .o_done    (o_done),
        .o_result  (o_result),
        .o_wr_en   (wr_en),
        .o_wr_addr (wr_addr),
        .o_wr_data (wr_data),
        .o_rd_en   (rd_en),
        .o_rd_addr (rd_addr),
        .i_rd_data (rd_data)
    );

    // Entry storage: kind, first pulse and last pulse per table position.
    sit_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // An accepted transaction must make the block busy on the next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    // The result strobe lands in a cycle in which a new start can be taken.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result delivered while still busy");

endmodule
